[hw/rtl/mlc_pkg.sv]
// Shared types, command codes and status codes of the method lookup cache.
package mlc_pkg;

   localparam int ENTRIES_DEF = 64;

   localparam logic [1:0] CMD_LOOKUP    = 2'd0;
   localparam logic [1:0] CMD_ADD       = 2'd1;
   localparam logic [1:0] CMD_CLEAR_SEL = 2'd2;
   localparam logic [1:0] CMD_CLEAR_ALL = 2'd3;

   localparam logic [1:0] ADD_OK      = 2'd0;
   localparam logic [1:0] ADD_PRESENT = 2'd1;
   localparam logic [1:0] ADD_FULL    = 2'd2;

   typedef struct packed {
      logic        valid;
      logic [31:0] selector;
      logic [31:0] class_id;
      logic [31:0] module_id;
      logic [31:0] method;
   } slot_type;

   typedef struct packed {
      logic capture;
      logic addr_clr;
      logic addr_step;
      logic init_wipe;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic addr_last;
   } dp_status_type;

endpackage

[hw/rtl/method_lookup_cache.sv]
// Top level of the method lookup cache: controller plus datapath.
//
// Channels: a request word (req_cmd, req_selector, req_class_id, req_module_id,
// req_method_in) is taken at a rising edge with start high and busy low. Commands are
// lookup, add, clear one selector and clear all. Every request yields exactly one
// response word, shown for a single cycle with rsp_strobe high; the receiver cannot
// stall it, so it must take the word in that cycle.
// Scan: each request reads every one of the ENTRIES slots once through the single
// read port of the slot RAM, one slot a cycle. The response is registered after the
// scan, a drain state and a finish state, and busy falls in the same cycle as it,
// so a new request is taken only once the previous one has been answered.
// Reset: synchronous, active high. After reset the block runs a clearing pass over
// every slot of the slot RAM with busy high; counters and the occupied count start
// at zero.
// rsp_hits, rsp_misses, rsp_full_clears and rsp_entry_clears wrap at 32 bits;
// rsp_occupied carries the valid slot count modulo 128.
module method_lookup_cache #(
   parameter int ENTRIES = mlc_pkg::ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_selector,
   input  logic [31:0] req_class_id,
   input  logic [31:0] req_module_id,
   input  logic [31:0] req_method_in,
   output logic        rsp_strobe,
   output logic        rsp_found,
   output logic [31:0] rsp_method_out,
   output logic [1:0]  rsp_add_status,
   output logic [31:0] rsp_hits,
   output logic [31:0] rsp_misses,
   output logic [31:0] rsp_full_clears,
   output logic [31:0] rsp_entry_clears,
   output logic [6:0]  rsp_occupied
);

   mlc_pkg::ctrl_cmd_type  ctrl_cmd;
   mlc_pkg::dp_status_type dp_status;

   mlc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (dp_status),
      .cmd    (ctrl_cmd)
   );

   mlc_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .req_cmd          (req_cmd),
      .req_selector     (req_selector),
      .req_class_id     (req_class_id),
      .req_module_id    (req_module_id),
      .req_method_in    (req_method_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_method_out   (rsp_method_out),
      .rsp_add_status   (rsp_add_status),
      .rsp_hits         (rsp_hits),
      .rsp_misses       (rsp_misses),
      .rsp_full_clears  (rsp_full_clears),
      .rsp_entry_clears (rsp_entry_clears),
      .rsp_occupied     (rsp_occupied)
   );

endmodule

[hw/rtl/mlc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mlc_ctrl.sv]
// Controller state machine: init sweep, idle, slot scan, drain and finish.
module mlc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mlc_pkg::dp_status_type status,
   output mlc_pkg::ctrl_cmd_type   cmd
);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_wipe = 1'b1;
            cmd.addr_step = 1'b1;
            if (status.addr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture  = 1'b1;
               cmd.addr_clr = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan      = 1'b1;
            cmd.addr_step = 1'b1;
            if (status.addr_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[hw/rtl/mlc_dp.sv]
// Datapath: request capture, slot RAM, scan compare, counters and result word.
module mlc_dp #(
   parameter int ENTRIES = mlc_pkg::ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mlc_pkg::ctrl_cmd_type  cmd,
   output mlc_pkg::dp_status_type status,
   input  logic [1:0]             req_cmd,
   input  logic [31:0]            req_selector,
   input  logic [31:0]            req_class_id,
   input  logic [31:0]            req_module_id,
   input  logic [31:0]            req_method_in,
   output logic                   rsp_strobe,
   output logic                   rsp_found,
   output logic [31:0]            rsp_method_out,
   output logic [1:0]             rsp_add_status,
   output logic [31:0]            rsp_hits,
   output logic [31:0]            rsp_misses,
   output logic [31:0]            rsp_full_clears,
   output logic [31:0]            rsp_entry_clears,
   output logic [6:0]             rsp_occupied
);

   localparam int AW    = $clog2(ENTRIES);
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

   // request word
   logic [1:0]  cmd_ff;
   logic [31:0] sel_ff, cls_ff, mod_ff, mth_ff;

   // scan state
   logic [AW-1:0]    addr_ff, addr_in;
   logic             eval_ff;
   logic [AW-1:0]    eval_addr_ff;
   logic             hit_ff, hit_in;
   logic [31:0]      hit_method_ff, hit_method_in;
   logic             free_ff, free_in;
   logic [AW-1:0]    free_addr_ff, free_addr_in;

   // counters
   logic [31:0]      hits_ff, hits_in;
   logic [31:0]      misses_ff, misses_in;
   logic [31:0]      fclr_ff, fclr_in;
   logic [31:0]      eclr_ff, eclr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [OCC_W+6:0] occ_ext;

   // result word
   logic             rsp_strobe_ff;
   logic             rsp_found_ff;
   logic [31:0]      rsp_method_ff;
   logic [1:0]       rsp_status_ff;
   logic [1:0]       status_in;

   // RAM ports
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   mlc_pkg::slot_type wr_data;
   mlc_pkg::slot_type rd_slot;
   logic              key_match, sel_match, clr_hit, add_write;

   mlc_ram #(
      .WIDTH ($bits(mlc_pkg::slot_type)),
      .DEPTH (ENTRIES)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.scan),
      .rd_addr (addr_ff),
      .rd_data (rd_slot)
   );

   assign status.addr_last = (addr_ff == LAST_ADDR);

   assign sel_match = rd_slot.valid && (rd_slot.selector == sel_ff);
   assign key_match = sel_match && (rd_slot.class_id == cls_ff)
                      && (rd_slot.module_id == mod_ff);
   assign clr_hit   = eval_ff && (cmd_ff == mlc_pkg::CMD_CLEAR_SEL) && sel_match;
   assign add_write = cmd.finish && (cmd_ff == mlc_pkg::CMD_ADD) && !hit_ff && free_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (cmd.init_wipe || (cmd.scan && (cmd_ff == mlc_pkg::CMD_CLEAR_ALL))) begin
         wr_en = 1'b1;
      end else if (clr_hit) begin
         wr_en         = 1'b1;
         wr_addr       = eval_addr_ff;
         wr_data       = rd_slot;
         wr_data.valid = 1'b0;
      end else if (add_write) begin
         wr_en             = 1'b1;
         wr_addr           = free_addr_ff;
         wr_data.valid     = 1'b1;
         wr_data.selector  = sel_ff;
         wr_data.class_id  = cls_ff;
         wr_data.module_id = mod_ff;
         wr_data.method    = mth_ff;
      end
   end

   always_comb begin
      addr_in       = addr_ff;
      hit_in        = hit_ff;
      hit_method_in = hit_method_ff;
      free_in       = free_ff;
      free_addr_in  = free_addr_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      fclr_in       = fclr_ff;
      eclr_in       = eclr_ff;
      occ_in        = occ_ff;
      status_in     = mlc_pkg::ADD_OK;

      if (cmd.addr_clr) begin
         addr_in = '0;
      end else if (cmd.addr_step) begin
         addr_in = status.addr_last ? '0 : addr_ff + AW'(1);
      end

      if (cmd.capture) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end

      if (eval_ff) begin
         if (key_match && !hit_ff) begin
            hit_in        = 1'b1;
            hit_method_in = rd_slot.method;
         end
         if (!rd_slot.valid && !free_ff) begin
            free_in      = 1'b1;
            free_addr_in = eval_addr_ff;
         end
      end

      if (clr_hit) begin
         occ_in = occ_ff - OCC_W'(1);
      end

      if (cmd.finish) begin
         case (cmd_ff)
            mlc_pkg::CMD_LOOKUP: begin
               if (hit_ff) begin
                  hits_in = hits_ff + 32'd1;
               end else begin
                  misses_in = misses_ff + 32'd1;
               end
            end
            mlc_pkg::CMD_ADD: begin
               if (hit_ff) begin
                  status_in = mlc_pkg::ADD_PRESENT;
               end else if (!free_ff) begin
                  status_in = mlc_pkg::ADD_FULL;
               end else begin
                  occ_in = occ_ff + OCC_W'(1);
               end
            end
            mlc_pkg::CMD_CLEAR_SEL: begin
               eclr_in = eclr_ff + 32'd1;
            end
            default: begin
               occ_in    = '0;
               hits_in   = '0;
               misses_in = '0;
               fclr_in   = fclr_ff + 32'd1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         eval_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         fclr_ff       <= '0;
         eclr_ff       <= '0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         addr_ff       <= addr_in;
         eval_ff       <= cmd.scan;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         fclr_ff       <= fclr_in;
         eclr_ff       <= eclr_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      eval_addr_ff  <= addr_ff;
      hit_method_ff <= hit_method_in;
      free_addr_ff  <= free_addr_in;
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         sel_ff <= req_selector;
         cls_ff <= req_class_id;
         mod_ff <= req_module_id;
         mth_ff <= req_method_in;
      end
      if (cmd.finish) begin
         rsp_found_ff  <= (cmd_ff == mlc_pkg::CMD_LOOKUP) && hit_ff;
         rsp_method_ff <= ((cmd_ff == mlc_pkg::CMD_LOOKUP) && hit_ff) ? hit_method_ff : '0;
         rsp_status_ff <= status_in;
      end
   end

   assign occ_ext          = {7'd0, occ_ff};
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_method_out   = rsp_method_ff;
   assign rsp_add_status   = rsp_status_ff;
   assign rsp_hits         = hits_ff;
   assign rsp_misses       = misses_ff;
   assign rsp_full_clears  = fclr_ff;
   assign rsp_entry_clears = eclr_ff;
   assign rsp_occupied     = occ_ext[6:0];

endmodule
